### rtl/core/dle_pkg.sv
package dle_pkg;

    localparam int TableEntriesDefault = 16;
    localparam int PayloadBytesDefault = 32;

    localparam int CfgIndexW = 3;
    localparam int CodeW = 8;

    localparam logic [7:0] EscapeReset = 8'd16;
    localparam logic [7:0] FrameStartReset = 8'd2;
    localparam logic [7:0] FrameEndReset = 8'd3;
    localparam logic [7:0] CommandStartReset = 8'd5;
    localparam logic [7:0] CommandEndReset = 8'd6;

    // Header position value that means no header has started yet.
    localparam logic [2:0] HeaderNone = 3'd4;
    localparam logic [2:0] HeaderLast = 3'd2;
    localparam logic [2:0] HeaderDone = 3'd3;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NO_END,
        ST_TABLE_FULL,
        ST_DOUBLE_START,
        ST_OVERRUN,
        ST_BAD_INDEX,
        ST_NO_ENTRY,
        ST_ROOM_SMALL
    } status_t;

    typedef enum logic [CfgIndexW-1:0] {
        REG_ESCAPE,
        REG_FRAME_START,
        REG_FRAME_END,
        REG_COMMAND_START,
        REG_COMMAND_END
    } cfg_index_t;

    typedef enum logic [1:0] {
        FLD_TYPE,
        FLD_ADDR_HIGH,
        FLD_ADDR_LOW,
        FLD_PAYLOAD
    } field_t;

    typedef struct packed {
        logic [CodeW-1:0] escape;
        logic [CodeW-1:0] frame_start;
        logic [CodeW-1:0] frame_end;
        logic [CodeW-1:0] command_start;
        logic [CodeW-1:0] command_end;
    } codes_t;

endpackage

### rtl/core/dle_ram.sv
module dle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/dle_cfg_regs.sv
module dle_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dle_pkg::CfgIndexW-1:0]   cfg_index,
    input  logic [dle_pkg::CodeW-1:0]       cfg_data,
    output dle_pkg::codes_t                 codes
);

    dle_pkg::codes_t codes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.escape <= dle_pkg::EscapeReset;
            codes_reg.frame_start <= dle_pkg::FrameStartReset;
            codes_reg.frame_end <= dle_pkg::FrameEndReset;
            codes_reg.command_start <= dle_pkg::CommandStartReset;
            codes_reg.command_end <= dle_pkg::CommandEndReset;
        end
        else if (cfg_we)
        begin
            case (dle_pkg::cfg_index_t'(cfg_index))
                dle_pkg::REG_ESCAPE:        codes_reg.escape <= cfg_data;
                dle_pkg::REG_FRAME_START:   codes_reg.frame_start <= cfg_data;
                dle_pkg::REG_FRAME_END:     codes_reg.frame_end <= cfg_data;
                dle_pkg::REG_COMMAND_START: codes_reg.command_start <= cfg_data;
                dle_pkg::REG_COMMAND_END:   codes_reg.command_end <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign codes = codes_reg;

endmodule

### rtl/core/dle_command_deframer.sv
// A message byte is handled in the cycle it is accepted; when it closes a chunk, or a
// chunk start finds the table full, one report request follows and input stalls until
// it is taken. A read request of a valid entry passes S_FIELDS, in which the entry
// fields come out of the table memories and are checked, then for each payload byte
// S_BYTE, a memory read, and S_OUT, in which the output register waits to be taken;
// the input is held until the last report is taken. Entry fields and payload bytes live
// in synchronous memories; valid bits and parser state are flip-flops cleared by reset.
module dle_command_deframer #(
    parameter int TABLE_ENTRIES = dle_pkg::TableEntriesDefault,
    parameter int PAYLOAD_BYTES = dle_pkg::PayloadBytesDefault
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dle_pkg::CfgIndexW-1:0]   cfg_index,
    input  logic [dle_pkg::CodeW-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            func,
    input  logic                            first_byte,
    input  logic                            last_byte,
    input  logic [7:0]                      data_byte,
    input  logic [7:0]                      entry_index,
    input  logic [7:0]                      room,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            report_kind,
    output logic [2:0]                      status,
    output logic [15:0]                     consumed,
    output logic [7:0]                      entry_type,
    output logic [15:0]                     entry_address,
    output logic [5:0]                      entry_length,
    output logic [7:0]                      entry_byte,
    output logic                            last_result
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SLOT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int PC_W = $clog2(PAYLOAD_BYTES + 1);
    localparam int PAY_DEPTH = TABLE_ENTRIES * PAYLOAD_BYTES;
    localparam int PA_W = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIELDS,
        S_BYTE,
        S_OUT
    } state_t;

    dle_pkg::codes_t codes;

    state_t state_reg, state_next;
    logic escape_reg, escape_next;
    logic frame_reg, frame_next;
    logic cmd_open_reg, cmd_open_next;
    logic cmd_closed_reg, cmd_closed_next;
    logic [2:0] hdr_pos_reg, hdr_pos_next;
    dle_pkg::field_t field_reg, field_next;
    logic [PC_W-1:0] pay_cnt_reg, pay_cnt_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [7:0] addr_high_reg, addr_high_next;
    logic chunk_reg, chunk_next;
    logic [15:0] count_reg, count_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [7:0] room_reg, room_next;
    logic [7:0] rd_type_reg, rd_type_next;
    logic [15:0] rd_addr_reg, rd_addr_next;
    logic [PC_W-1:0] rd_len_reg, rd_len_next;
    logic [PC_W-1:0] rd_k_reg, rd_k_next;
    logic [PA_W-1:0] rd_base_reg, rd_base_next;
    logic more_reg, more_next;
    logic out_valid_reg, out_valid_next;
    logic kind_reg, kind_next;
    dle_pkg::status_t status_reg, status_next;
    logic [15:0] consumed_reg, consumed_next;
    logic [7:0] otype_reg, otype_next;
    logic [15:0] oaddr_reg, oaddr_next;
    logic [5:0] olen_reg, olen_next;
    logic [7:0] obyte_reg, obyte_next;
    logic olast_reg, olast_next;

    logic type_we, addr_we, len_we, pay_we;
    logic [IDX_W-1:0] field_waddr;
    logic [7:0] type_wdata;
    logic [15:0] addr_wdata;
    logic [PC_W-1:0] len_wdata;
    logic [PA_W-1:0] pay_waddr, pay_raddr;
    logic [7:0] pay_wdata;
    logic [IDX_W-1:0] field_raddr;
    logic [7:0] type_q;
    logic [15:0] addr_q;
    logic [PC_W-1:0] len_q;
    logic [7:0] pay_q;

    logic in_take, out_take;
    logic free_found;
    logic [IDX_W-1:0] free_slot;

    dle_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .codes     (codes)
    );

    dle_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_type_ram (
        .clk   (clk),
        .we    (type_we),
        .waddr (field_waddr),
        .wdata (type_wdata),
        .raddr (field_raddr),
        .rdata (type_q)
    );

    dle_ram #(.WIDTH(16), .DEPTH(TABLE_ENTRIES)) u_addr_ram (
        .clk   (clk),
        .we    (addr_we),
        .waddr (field_waddr),
        .wdata (addr_wdata),
        .raddr (field_raddr),
        .rdata (addr_q)
    );

    dle_ram #(.WIDTH(PC_W), .DEPTH(TABLE_ENTRIES)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (field_waddr),
        .wdata (len_wdata),
        .raddr (field_raddr),
        .rdata (len_q)
    );

    dle_ram #(.WIDTH(8), .DEPTH(PAY_DEPTH)) u_pay_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (pay_wdata),
        .raddr (pay_raddr),
        .rdata (pay_q)
    );

    assign field_raddr = entry_index[IDX_W-1:0];
    assign in_take = in_valid && (state_reg == S_IDLE);
    assign out_take = out_valid_reg && !out_stall;

    always_comb
    begin
        free_found = 1'b0;
        free_slot = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        logic esc, fo, co, cc, go, fall, act;
        logic [2:0] hp;
        dle_pkg::field_t fp;
        logic [PC_W-1:0] pc;
        logic [SLOT_W-1:0] sl;
        logic [IDX_W-1:0] sl_sel;
        logic [7:0] ah, b;
        logic [15:0] cnt;
        dle_pkg::status_t st;
        logic [PA_W-1:0] base;
        logic last_k;

        state_next = state_reg;
        escape_next = escape_reg;
        frame_next = frame_reg;
        cmd_open_next = cmd_open_reg;
        cmd_closed_next = cmd_closed_reg;
        hdr_pos_next = hdr_pos_reg;
        field_next = field_reg;
        pay_cnt_next = pay_cnt_reg;
        slot_next = slot_reg;
        addr_high_next = addr_high_reg;
        chunk_next = chunk_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        rd_idx_next = rd_idx_reg;
        room_next = room_reg;
        rd_type_next = rd_type_reg;
        rd_addr_next = rd_addr_reg;
        rd_len_next = rd_len_reg;
        rd_k_next = rd_k_reg;
        rd_base_next = rd_base_reg;
        more_next = more_reg;
        out_valid_next = out_valid_reg && !out_take;
        kind_next = kind_reg;
        status_next = status_reg;
        consumed_next = consumed_reg;
        otype_next = otype_reg;
        oaddr_next = oaddr_reg;
        olen_next = olen_reg;
        obyte_next = obyte_reg;
        olast_next = olast_reg;

        type_we = 1'b0;
        addr_we = 1'b0;
        len_we = 1'b0;
        pay_we = 1'b0;
        field_waddr = '0;
        type_wdata = data_byte;
        addr_wdata = '0;
        len_wdata = '0;
        pay_waddr = '0;
        pay_wdata = data_byte;
        pay_raddr = rd_base_reg + PA_W'(rd_k_reg);

        esc = escape_reg;
        fo = frame_reg;
        co = cmd_open_reg;
        cc = cmd_closed_reg;
        hp = hdr_pos_reg;
        fp = field_reg;
        pc = pay_cnt_reg;
        sl = slot_reg;
        ah = addr_high_reg;
        cnt = count_reg;
        go = 1'b1;
        fall = 1'b1;
        act = chunk_reg;
        st = dle_pkg::ST_OK;
        b = data_byte;
        sl_sel = '0;
        base = '0;
        last_k = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take && func)
                begin
                    if (entry_index >= 8'(TABLE_ENTRIES))
                    begin
                        out_valid_next = 1'b1;
                        kind_next = 1'b1;
                        status_next = dle_pkg::ST_BAD_INDEX;
                        consumed_next = '0;
                        otype_next = '0;
                        oaddr_next = '0;
                        olen_next = '0;
                        obyte_next = '0;
                        olast_next = 1'b1;
                        more_next = 1'b0;
                        state_next = S_OUT;
                    end
                    else if (!valid_reg[entry_index[IDX_W-1:0]])
                    begin
                        out_valid_next = 1'b1;
                        kind_next = 1'b1;
                        status_next = dle_pkg::ST_NO_ENTRY;
                        consumed_next = '0;
                        otype_next = '0;
                        oaddr_next = '0;
                        olen_next = '0;
                        obyte_next = '0;
                        olast_next = 1'b1;
                        more_next = 1'b0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        rd_idx_next = entry_index[IDX_W-1:0];
                        room_next = room;
                        state_next = S_FIELDS;
                    end
                end
                else if (in_take)
                begin
                    if (first_byte)
                    begin
                        esc = 1'b0;
                        fo = 1'b0;
                        co = 1'b0;
                        cc = 1'b0;
                        hp = dle_pkg::HeaderNone;
                        fp = dle_pkg::FLD_TYPE;
                        pc = '0;
                        ah = '0;
                        cnt = '0;
                        act = free_found;
                        if (free_found)
                        begin
                            sl = SLOT_W'(free_slot);
                        end
                    end
                    if (act)
                    begin
                        if (cnt != 16'hFFFF)
                        begin
                            cnt = cnt + 16'd1;
                        end
                        if (b == codes.escape)
                        begin
                            if (hp <= dle_pkg::HeaderLast)
                            begin
                            end
                            else if (!esc)
                            begin
                                esc = 1'b1;
                                fall = 1'b0;
                            end
                            else
                            begin
                                esc = 1'b0;
                            end
                        end
                        else if (b == codes.frame_start)
                        begin
                            if (esc)
                            begin
                                fo = 1'b1;
                                esc = 1'b0;
                                hp = '0;
                                fall = 1'b0;
                            end
                        end
                        else if (b == codes.frame_end)
                        begin
                            if (esc)
                            begin
                                esc = 1'b0;
                                if (fo)
                                begin
                                    go = 1'b0;
                                    st = dle_pkg::ST_OK;
                                    fall = 1'b0;
                                end
                            end
                        end
                        else if (b == codes.command_start)
                        begin
                            if (esc)
                            begin
                                fall = 1'b0;
                                if (co)
                                begin
                                    go = 1'b0;
                                    st = dle_pkg::ST_DOUBLE_START;
                                end
                                else
                                begin
                                    co = 1'b1;
                                    esc = 1'b0;
                                    if (cc)
                                    begin
                                        cc = 1'b0;
                                        sl = sl + SLOT_W'(1);
                                        if (sl >= SLOT_W'(TABLE_ENTRIES))
                                        begin
                                            go = 1'b0;
                                            st = dle_pkg::ST_OVERRUN;
                                        end
                                    end
                                end
                            end
                        end
                        else if (b == codes.command_end)
                        begin
                            if (esc)
                            begin
                                co = 1'b0;
                                cc = 1'b1;
                                esc = 1'b0;
                                pc = '0;
                                fp = dle_pkg::FLD_TYPE;
                                fall = 1'b0;
                            end
                        end

                        sl_sel = sl[IDX_W-1:0];
                        field_waddr = sl_sel;
                        if (fall && fo && !co)
                        begin
                            if (hp < dle_pkg::HeaderDone)
                            begin
                                hp = hp + 3'd1;
                            end
                        end
                        else if (fall && fo && co && (sl < SLOT_W'(TABLE_ENTRIES)))
                        begin
                            case (fp)
                                dle_pkg::FLD_TYPE:
                                begin
                                    type_we = 1'b1;
                                    fp = dle_pkg::FLD_ADDR_HIGH;
                                end
                                dle_pkg::FLD_ADDR_HIGH:
                                begin
                                    ah = b;
                                    fp = dle_pkg::FLD_ADDR_LOW;
                                end
                                dle_pkg::FLD_ADDR_LOW:
                                begin
                                    addr_we = 1'b1;
                                    addr_wdata = {addr_high_reg, b};
                                    len_we = 1'b1;
                                    len_wdata = '0;
                                    valid_next[sl_sel] = 1'b1;
                                    fp = dle_pkg::FLD_PAYLOAD;
                                end
                                default:
                                begin
                                    if (pc < PC_W'(PAYLOAD_BYTES))
                                    begin
                                        pay_we = 1'b1;
                                        pay_waddr = PA_W'(int'(sl_sel) * PAYLOAD_BYTES)
                                                    + PA_W'(pc);
                                        pc = pc + PC_W'(1);
                                        len_we = 1'b1;
                                        len_wdata = pc;
                                    end
                                end
                            endcase
                        end

                        if (!go || last_byte)
                        begin
                            act = 1'b0;
                            out_valid_next = 1'b1;
                            kind_next = 1'b0;
                            status_next = go ? dle_pkg::ST_NO_END : st;
                            consumed_next = cnt;
                            otype_next = '0;
                            oaddr_next = '0;
                            olen_next = '0;
                            obyte_next = '0;
                            olast_next = 1'b1;
                            more_next = 1'b0;
                            state_next = S_OUT;
                        end
                    end
                    else if (first_byte)
                    begin
                        out_valid_next = 1'b1;
                        kind_next = 1'b0;
                        status_next = dle_pkg::ST_TABLE_FULL;
                        consumed_next = '0;
                        otype_next = '0;
                        oaddr_next = '0;
                        olen_next = '0;
                        obyte_next = '0;
                        olast_next = 1'b1;
                        more_next = 1'b0;
                        state_next = S_OUT;
                    end

                    escape_next = esc;
                    frame_next = fo;
                    cmd_open_next = co;
                    cmd_closed_next = cc;
                    hdr_pos_next = hp;
                    field_next = fp;
                    pay_cnt_next = pc;
                    slot_next = sl;
                    addr_high_next = ah;
                    count_next = cnt;
                    chunk_next = act;
                end
            end

            S_FIELDS:
            begin
                if (8'(len_q) > room_reg)
                begin
                    out_valid_next = 1'b1;
                    kind_next = 1'b1;
                    status_next = dle_pkg::ST_ROOM_SMALL;
                    consumed_next = '0;
                    otype_next = '0;
                    oaddr_next = '0;
                    olen_next = '0;
                    obyte_next = '0;
                    olast_next = 1'b1;
                    more_next = 1'b0;
                    state_next = S_OUT;
                end
                else
                begin
                    valid_next[rd_idx_reg] = 1'b0;
                    rd_type_next = type_q;
                    rd_addr_next = addr_q;
                    rd_len_next = len_q;
                    if (len_q == '0)
                    begin
                        out_valid_next = 1'b1;
                        kind_next = 1'b1;
                        status_next = dle_pkg::ST_OK;
                        consumed_next = '0;
                        otype_next = type_q;
                        oaddr_next = addr_q;
                        olen_next = '0;
                        obyte_next = '0;
                        olast_next = 1'b1;
                        more_next = 1'b0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        base = PA_W'(int'(rd_idx_reg) * PAYLOAD_BYTES);
                        rd_base_next = base;
                        rd_k_next = '0;
                        pay_raddr = base;
                        state_next = S_BYTE;
                    end
                end
            end

            S_BYTE:
            begin
                last_k = (rd_k_reg == rd_len_reg - PC_W'(1));
                out_valid_next = 1'b1;
                kind_next = 1'b1;
                status_next = dle_pkg::ST_OK;
                consumed_next = '0;
                otype_next = rd_type_reg;
                oaddr_next = rd_addr_reg;
                olen_next = 6'(rd_len_reg);
                obyte_next = pay_q;
                olast_next = last_k;
                more_next = !last_k;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (out_take)
                begin
                    if (more_reg)
                    begin
                        rd_k_next = rd_k_reg + PC_W'(1);
                        pay_raddr = rd_base_reg + PA_W'(rd_k_reg + PC_W'(1));
                        state_next = S_BYTE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            escape_reg <= 1'b0;
            frame_reg <= 1'b0;
            cmd_open_reg <= 1'b0;
            cmd_closed_reg <= 1'b0;
            hdr_pos_reg <= dle_pkg::HeaderNone;
            field_reg <= dle_pkg::FLD_TYPE;
            pay_cnt_reg <= '0;
            slot_reg <= '0;
            addr_high_reg <= '0;
            chunk_reg <= 1'b0;
            count_reg <= '0;
            valid_reg <= '0;
            more_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            escape_reg <= escape_next;
            frame_reg <= frame_next;
            cmd_open_reg <= cmd_open_next;
            cmd_closed_reg <= cmd_closed_next;
            hdr_pos_reg <= hdr_pos_next;
            field_reg <= field_next;
            pay_cnt_reg <= pay_cnt_next;
            slot_reg <= slot_next;
            addr_high_reg <= addr_high_next;
            chunk_reg <= chunk_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            more_reg <= more_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        room_reg <= room_next;
        rd_type_reg <= rd_type_next;
        rd_addr_reg <= rd_addr_next;
        rd_len_reg <= rd_len_next;
        rd_k_reg <= rd_k_next;
        rd_base_reg <= rd_base_next;
        kind_reg <= kind_next;
        status_reg <= status_next;
        consumed_reg <= consumed_next;
        otype_reg <= otype_next;
        oaddr_reg <= oaddr_next;
        olen_reg <= olen_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign report_kind = kind_reg;
    assign status = status_reg;
    assign consumed = consumed_reg;
    assign entry_type = otype_reg;
    assign entry_address = oaddr_reg;
    assign entry_length = olen_reg;
    assign entry_byte = obyte_reg;
    assign last_result = olast_reg;

endmodule
